FILE: hdl/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants for the Harris corner response core.
// ----------------------------------------------------------------------------
package hcr_pkg;

   localparam int GRAD_BITS  = 12;
   localparam int K_BITS     = 16;
   localparam int FW_BITS    = 11;
   localparam int FH_BITS    = 13;
   localparam int RESP_BITS  = 51;
   localparam int ROW_BITS   = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_K_COEFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 2'd2;

   localparam logic [K_BITS-1:0]  K_RESET      = 16'd2621;
   localparam logic [FW_BITS-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [FH_BITS-1:0] HEIGHT_RESET = 13'd480;

   typedef logic signed [GRAD_BITS-1:0] grad_type;

   // one window column plus what the back end must do with it
   typedef struct packed {
      logic     edge_out;
      logic     mid_out;
      logic     first_col;
      logic     last;
      grad_type tx;
      grad_type ty;
      grad_type mx;
      grad_type my;
      grad_type bx;
      grad_type by;
   } item_type;

endpackage

FILE: hdl/harris_corner_response_core.sv
// ----------------------------------------------------------------------------
// harris_corner_response_core
// Streaming 3x3 Harris corner response over raster gradient pairs.
// ----------------------------------------------------------------------------
// Input beats (req_) carry one gradient pair per pixel in row-major order;
// req_drain beats are bubbles while pixels are expected and flush steps after
// the last row. A frame needs frame_width+1 flush beats after its last pixel.
// Result beats (rsp_) follow in pixel order, one row plus one pixel of input
// behind; the last result of a frame has rsp_frame_end set.
// Throughput is one beat per clock while req_stall is low. A beat accepted at
// the input passes the line store read register, the queue, and seven back
// end stages (column products, column sums, window sums, the det and trace
// products, the k scaling, the subtract and the clamp) to the output register.
// A stalled rsp_ holds its beat and freezes the back end; the front keeps
// taking beats until the 4-entry queue holds three, then raises req_stall.
// Reset clears the raster position, window and pipeline and loads the default
// k, width and height. Line stores need no clearing. csr_ writes must be made
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module harris_corner_response_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [hcr_pkg::GRAD_BITS-1:0] req_grad_x,
   input  logic signed [hcr_pkg::GRAD_BITS-1:0] req_grad_y,
   input  logic                                 req_drain,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [hcr_pkg::RESP_BITS-1:0]        rsp_corner_response,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_write_en,
   input  logic [hcr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hcr_pkg::CSR_DATA_W-1:0]       csr_data
);
   import hcr_pkg::*;

   logic [K_BITS-1:0]  k_ff;
   logic [FW_BITS-1:0] width_ff;
   logic [FH_BITS-1:0] height_ff;
   logic               queue_room, queue_empty, push, pop;
   item_type           push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= K_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_K_COEFF: k_ff      <= csr_data[K_BITS-1:0];
            CSR_WIDTH:   width_ff  <= csr_data[FW_BITS-1:0];
            CSR_HEIGHT:  height_ff <= csr_data[FH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   hcr_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_grad_x   (req_grad_x),
      .req_grad_y   (req_grad_y),
      .req_drain    (req_drain),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .queue_room   (queue_room),
      .push         (push),
      .push_item    (push_item)
   );

   hcr_fifo #(
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty),
      .room      (queue_room)
   );

   hcr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .k_coeff             (k_ff),
      .pop_item            (pop_item),
      .empty               (queue_empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_corner_response (rsp_corner_response),
      .rsp_frame_end       (rsp_frame_end)
   );

endmodule

FILE: hdl/hcr_ram.sv
// ----------------------------------------------------------------------------
// hcr_ram
// Generic RAM, one write port, two registered read ports (read old data).
// ----------------------------------------------------------------------------
module hcr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hdl/hcr_fifo.sv
// ----------------------------------------------------------------------------
// hcr_fifo
// Short queue of window columns between the front and back ends.
// ----------------------------------------------------------------------------
module hcr_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hcr_pkg::item_type push_item,
   input  logic              pop,
   output hcr_pkg::item_type pop_item,
   output logic              empty,
   output logic              room
);
   import hcr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   // one slot held back for the beat in the front's read stage
   assign room     = (count_ff <= (PW+1)'(DEPTH - 2));

endmodule

FILE: hdl/hcr_front.sv
// ----------------------------------------------------------------------------
// hcr_front
// Raster position tracking, line store access and window column assembly.
// ----------------------------------------------------------------------------
module hcr_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [hcr_pkg::GRAD_BITS-1:0] req_grad_x,
   input  logic signed [hcr_pkg::GRAD_BITS-1:0] req_grad_y,
   input  logic                          req_drain,
   input  logic [hcr_pkg::FW_BITS-1:0]   frame_width,
   input  logic [hcr_pkg::FH_BITS-1:0]   frame_height,
   input  logic                          queue_room,
   output logic                          push,
   output hcr_pkg::item_type             push_item
);
   import hcr_pkg::*;

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int DEPTH = 2 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [ROW_BITS-1:0]  wn, hn, cnext;
   logic [CW-1:0]        c1;
   logic [ROW_BITS-1:0]  r1;
   logic                 flushing, last, take;
   logic [AW-1:0]        cur_addr, prev_addr;
   logic [2*GRAD_BITS-1:0] cur_q, prev_q;

   logic                 s1_valid_ff;
   logic                 s1_edge_ff, s1_mid_ff, s1_first_ff, s1_last_ff;
   logic                 s1_row_one_ff, s1_flush_ff;
   grad_type             s1_gx_ff, s1_gy_ff;

   always_comb begin
      if (frame_width < FW_BITS'(3)) begin
         wn = ROW_BITS'(3);
      end else if (ROW_BITS'(frame_width) > ROW_BITS'(MAX_WIDTH)) begin
         wn = ROW_BITS'(MAX_WIDTH);
      end else begin
         wn = ROW_BITS'(frame_width);
      end
      if (frame_height < FH_BITS'(3)) begin
         hn = ROW_BITS'(3);
      end else if (ROW_BITS'(frame_height) > ROW_BITS'(MAX_HEIGHT)) begin
         hn = ROW_BITS'(MAX_HEIGHT);
      end else begin
         hn = ROW_BITS'(frame_height);
      end
   end

   always_comb begin
      c1 = col_ff;
      r1 = row_ff;
      if (ROW_BITS'(col_ff) >= wn) begin
         c1 = '0;
         r1 = row_ff + 1'b1;
      end
      if (r1 > hn + 1'b1 || (r1 == hn + 1'b1 && c1 != '0)) begin
         c1 = '0;
         r1 = '0;
      end
      flushing  = (r1 >= hn);
      last      = (r1 == hn + 1'b1);
      req_stall = !queue_room;
      take      = req_valid && !req_stall && (flushing || !req_drain);
      cnext     = ROW_BITS'(c1) + 1'b1;
      col_in    = col_ff;
      row_in    = row_ff;
      if (take) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (cnext >= wn) begin
            col_in = '0;
            row_in = r1 + 1'b1;
         end else begin
            col_in = cnext[CW-1:0];
            row_in = r1;
         end
      end
      cur_addr  = r1[0] ? AW'(MAX_WIDTH) + AW'(c1) : AW'(c1);
      prev_addr = r1[0] ? AW'(c1) : AW'(MAX_WIDTH) + AW'(c1);
   end

   hcr_ram #(
      .WIDTH (2 * GRAD_BITS),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (take && !flushing),
      .wr_addr   (cur_addr),
      .wr_data   ({req_grad_x, req_grad_y}),
      .rd_addr_a (cur_addr),
      .rd_data_a (cur_q),
      .rd_addr_b (prev_addr),
      .rd_data_b (prev_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_edge_ff    <= (c1 == '0) && (r1 >= ROW_BITS'(2));
         s1_mid_ff     <= (c1 != '0) && (r1 >= ROW_BITS'(1));
         s1_first_ff   <= (c1 == '0);
         s1_last_ff    <= last;
         s1_row_one_ff <= (r1 == ROW_BITS'(1));
         s1_flush_ff   <= flushing;
         s1_gx_ff      <= req_grad_x;
         s1_gy_ff      <= req_grad_y;
      end
   end

   always_comb begin
      push                = s1_valid_ff;
      push_item.edge_out  = s1_edge_ff;
      push_item.mid_out   = s1_mid_ff;
      push_item.first_col = s1_first_ff;
      push_item.last      = s1_last_ff;
      push_item.mx        = prev_q[2*GRAD_BITS-1:GRAD_BITS];
      push_item.my        = prev_q[GRAD_BITS-1:0];
      push_item.tx        = s1_row_one_ff ? prev_q[2*GRAD_BITS-1:GRAD_BITS]
                                          : cur_q[2*GRAD_BITS-1:GRAD_BITS];
      push_item.ty        = s1_row_one_ff ? prev_q[GRAD_BITS-1:0] : cur_q[GRAD_BITS-1:0];
      push_item.bx        = s1_flush_ff ? prev_q[2*GRAD_BITS-1:GRAD_BITS] : s1_gx_ff;
      push_item.by        = s1_flush_ff ? prev_q[GRAD_BITS-1:0] : s1_gy_ff;
   end

endmodule

FILE: hdl/hcr_back.sv
// ----------------------------------------------------------------------------
// hcr_back
// Column products, 3x3 window sums and the det - k*trace^2 response pipeline.
// ----------------------------------------------------------------------------
module hcr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [hcr_pkg::K_BITS-1:0]      k_coeff,
   input  hcr_pkg::item_type               pop_item,
   input  logic                            empty,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hcr_pkg::RESP_BITS-1:0]   rsp_corner_response,
   output logic                            rsp_frame_end
);
   import hcr_pkg::*;

   localparam int PW = 2 * GRAD_BITS;
   localparam int SW = PW + 4;
   localparam int DW = 2 * SW;
   localparam int TW = 2 * SW + 2;

   logic en;

   // stage 1: products
   logic                 b1_valid_ff, b1_edge_ff, b1_mid_ff, b1_first_ff, b1_last_ff;
   logic signed [PW-1:0] b1_xx_ff [3];
   logic signed [PW-1:0] b1_yy_ff [3];
   logic signed [PW-1:0] b1_xy_ff [3];
   // stage 2: column sums
   logic                 b2_valid_ff, b2_edge_ff, b2_mid_ff, b2_first_ff, b2_last_ff;
   logic signed [SW-1:0] b2_xx_ff, b2_yy_ff, b2_xy_ff;
   // window of column sums
   logic signed [SW-1:0] w_xx_ff [3];
   logic signed [SW-1:0] w_yy_ff [3];
   logic signed [SW-1:0] w_xy_ff [3];
   logic signed [SW-1:0] s_xx, s_yy, s_xy;
   // stage 3: window sums
   logic                 b3_valid_ff, b3_last_ff;
   logic signed [SW-1:0] b3_xx_ff, b3_yy_ff, b3_xy_ff;
   // stage 4: products
   logic                 b4_valid_ff, b4_last_ff;
   logic [DW-1:0]        b4_p1_ff, b4_p2_ff;
   logic [TW-1:0]        b4_tr2_ff;
   logic [SW-1:0]        mag;
   logic [SW:0]          tr;
   // stage 5
   logic                 b5_valid_ff, b5_last_ff;
   logic [DW-1:0]        b5_det_ff;
   logic [TW-1:0]        b5_hi_ff;
   logic [K_BITS-1:0]    b5_lo_ff;
   logic [2*K_BITS-1:0]  lo_prod;
   // stage 6
   logic                 b6_valid_ff, b6_last_ff;
   logic [TW-1:0]        b6_det_ff, b6_sub_ff;
   // output
   logic                 out_valid_ff, out_last_ff;
   logic [RESP_BITS-1:0] out_resp_ff;
   logic [TW-1:0]        diff;

   assign en  = !out_valid_ff || !rsp_stall;
   assign pop = en && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         b5_valid_ff  <= 1'b0;
         b6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= pop;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff && (b2_edge_ff || b2_mid_ff);
         b4_valid_ff  <= b3_valid_ff;
         b5_valid_ff  <= b4_valid_ff;
         b6_valid_ff  <= b5_valid_ff;
         out_valid_ff <= b6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_edge_ff  <= pop_item.edge_out;
         b1_mid_ff   <= pop_item.mid_out;
         b1_first_ff <= pop_item.first_col;
         b1_last_ff  <= pop_item.last;
         b1_xx_ff[0] <= pop_item.tx * pop_item.tx;
         b1_xx_ff[1] <= pop_item.mx * pop_item.mx;
         b1_xx_ff[2] <= pop_item.bx * pop_item.bx;
         b1_yy_ff[0] <= pop_item.ty * pop_item.ty;
         b1_yy_ff[1] <= pop_item.my * pop_item.my;
         b1_yy_ff[2] <= pop_item.by * pop_item.by;
         b1_xy_ff[0] <= pop_item.tx * pop_item.ty;
         b1_xy_ff[1] <= pop_item.mx * pop_item.my;
         b1_xy_ff[2] <= pop_item.bx * pop_item.by;

         b2_edge_ff  <= b1_edge_ff;
         b2_mid_ff   <= b1_mid_ff;
         b2_first_ff <= b1_first_ff;
         b2_last_ff  <= b1_last_ff;
         b2_xx_ff    <= SW'(b1_xx_ff[0]) + SW'(b1_xx_ff[1]) + SW'(b1_xx_ff[2]);
         b2_yy_ff    <= SW'(b1_yy_ff[0]) + SW'(b1_yy_ff[1]) + SW'(b1_yy_ff[2]);
         b2_xy_ff    <= SW'(b1_xy_ff[0]) + SW'(b1_xy_ff[1]) + SW'(b1_xy_ff[2]);
      end
   end

   // edge result: right border replicated from the old window; else new column plus last two
   always_comb begin
      if (b2_edge_ff) begin
         s_xx = w_xx_ff[1] + (w_xx_ff[2] <<< 1);
         s_yy = w_yy_ff[1] + (w_yy_ff[2] <<< 1);
         s_xy = w_xy_ff[1] + (w_xy_ff[2] <<< 1);
      end else begin
         s_xx = w_xx_ff[1] + w_xx_ff[2] + b2_xx_ff;
         s_yy = w_yy_ff[1] + w_yy_ff[2] + b2_yy_ff;
         s_xy = w_xy_ff[1] + w_xy_ff[2] + b2_xy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            w_xx_ff[i] <= '0;
            w_yy_ff[i] <= '0;
            w_xy_ff[i] <= '0;
         end
      end else if (en && b2_valid_ff && !b2_last_ff) begin
         if (b2_first_ff) begin
            for (int i = 0; i < 3; i++) begin
               w_xx_ff[i] <= b2_xx_ff;
               w_yy_ff[i] <= b2_yy_ff;
               w_xy_ff[i] <= b2_xy_ff;
            end
         end else begin
            w_xx_ff[0] <= w_xx_ff[1];
            w_xx_ff[1] <= w_xx_ff[2];
            w_xx_ff[2] <= b2_xx_ff;
            w_yy_ff[0] <= w_yy_ff[1];
            w_yy_ff[1] <= w_yy_ff[2];
            w_yy_ff[2] <= b2_yy_ff;
            w_xy_ff[0] <= w_xy_ff[1];
            w_xy_ff[1] <= w_xy_ff[2];
            w_xy_ff[2] <= b2_xy_ff;
         end
      end
   end

   always_comb begin
      mag     = b3_xy_ff[SW-1] ? SW'(-b3_xy_ff) : SW'(b3_xy_ff);
      tr      = {1'b0, b3_xx_ff} + {1'b0, b3_yy_ff};
      lo_prod = k_coeff * b4_tr2_ff[K_BITS-1:0];
      diff    = b6_det_ff - b6_sub_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b3_last_ff <= b2_last_ff;
         b3_xx_ff   <= s_xx;
         b3_yy_ff   <= s_yy;
         b3_xy_ff   <= s_xy;

         b4_last_ff <= b3_last_ff;
         b4_p1_ff   <= DW'($unsigned(b3_xx_ff)) * DW'($unsigned(b3_yy_ff));
         b4_p2_ff   <= DW'(mag) * DW'(mag);
         b4_tr2_ff  <= TW'(tr) * TW'(tr);

         b5_last_ff <= b4_last_ff;
         b5_det_ff  <= b4_p1_ff - b4_p2_ff;
         b5_hi_ff   <= TW'(k_coeff) * TW'(b4_tr2_ff[TW-1:K_BITS]);
         b5_lo_ff   <= lo_prod[2*K_BITS-1:K_BITS];

         b6_last_ff <= b5_last_ff;
         b6_det_ff  <= TW'(b5_det_ff);
         b6_sub_ff  <= b5_hi_ff + TW'(b5_lo_ff);

         out_last_ff <= b6_last_ff;
         out_resp_ff <= (b6_det_ff > b6_sub_ff) ? diff[RESP_BITS-1:0] : '0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_corner_response = out_resp_ff;
   assign rsp_frame_end       = out_last_ff;

endmodule
